### src/lss_pkg.sv
// Shared types and constants of the LIFO stack with search.
package lss_pkg;

  localparam int unsigned DefDepth = 8;   // default number of stack cells
  localparam int unsigned DataW    = 32;  // width of one stacked word
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutW     = 4;   // width of position and count fields

  // request codes
  localparam logic [ReqW-1:0] REQ_PUSH   = 2'd0;
  localparam logic [ReqW-1:0] REQ_POP    = 2'd1;
  localparam logic [ReqW-1:0] REQ_SEARCH = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic push;   // take word from the neighbor above (toward the top)
    logic pop;    // take word from the neighbor below
    logic load;   // capture compare result into the hit flag
    logic shift;  // move hit flags one cell toward the bottom end
  } cell_ctrl_t;

endpackage

### src/lss_intf.sv
// Request and response channel interfaces.
interface lss_req_if;
  logic                        valid;
  logic                        ready;
  logic [lss_pkg::ReqW-1:0]    req_type;
  logic [lss_pkg::DataW-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface lss_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lss_pkg::StatusW-1:0]  status;
  logic [lss_pkg::DataW-1:0]    data;
  logic [lss_pkg::OutW-1:0]     position;
  logic [lss_pkg::OutW-1:0]     count;

  modport source (output valid, output status, output data, output position,
                  output count, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input count, output ready);
endinterface

### src/lss_cell.sv
// One stack cell: a stored word plus a search hit flag.
module lss_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [lss_pkg::DataW-1:0]  key_i,
  input  logic [lss_pkg::DataW-1:0]  up_data_i,
  input  logic [lss_pkg::DataW-1:0]  dn_data_i,
  input  logic                       hit_i,
  input  logic                       in_range_i,
  output logic [lss_pkg::DataW-1:0]  data_o,
  output logic                       hit_o
);

  logic [lss_pkg::DataW-1:0] data_q, data_d;
  logic                      hit_q, hit_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = up_data_i;
    end else if (ctrl_i.pop) begin
      data_d = dn_data_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.load) begin
      hit_d = in_range_i && (data_q == key_i);
    end else if (ctrl_i.shift) begin
      hit_d = hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

### src/lifo_stack_with_search.sv
// Top level: LIFO stack of words built as a shifting chain of cells, with search.
// Usage:
//   req_i (sink): one item per request, req_type 0 push, 1 pop, 2 search,
//     value is the word to push or the key to look for.
//   rsp_o (source): exactly one item per request with status, popped data,
//     1-based match position from the bottom, and the entry count afterward.
// Timing:
//   Push, pop and unused codes finish in the cycle they are accepted; the
//   result shows on rsp_o in the next cycle and, while rsp_o takes it, a new
//   request can be taken then, so these run at one item per cycle.
//   A search on a non-empty stack loads the hit flags in its accept cycle,
//   then walks them along the chain one cell per cycle from the deepest cell
//   and stops at the first hit or after the last step. No request is
//   accepted during the walk.
// Reset: rst_ni clears the count, the scan state and the output valid flag.
// Stall:
//   The result sits in an output register; a request is still accepted while
//   that register drains in the same cycle. If rsp_o stays stalled, req_i
//   ready drops and a finished search waits in place.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = lss_pkg::DefDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lss_req_if.sink        req_i,
  lss_rsp_if.source      rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);            // count width
  localparam int unsigned JW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // scan step width
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [JW-1:0] LastStep = JW'(DEPTH - 1);

  // scan sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [JW-1:0] step_q, step_d;

  // output register
  logic                          out_valid_q;
  logic [lss_pkg::StatusW-1:0]   out_status_q, out_status_d;
  logic [lss_pkg::DataW-1:0]     out_data_q, out_data_d;
  logic [CW-1:0]                 out_pos_q, out_pos_d;
  logic [CW-1:0]                 out_count_q, out_count_d;
  logic                          out_load;
  logic                          out_free;

  // cell chain
  lss_pkg::cell_ctrl_t           ctrl;
  logic [lss_pkg::DataW-1:0]     cell_data [DEPTH];
  logic                          cell_hit  [DEPTH];
  logic                          tail_hit;
  logic [CW-1:0]                 scan_pos;

  logic in_fire;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire     = req_i.valid && req_i.ready;
  assign tail_hit    = cell_hit[DEPTH-1];

  // hit in the deepest cell after step shifts came from cell DEPTH-1-step,
  // which is position count - (DEPTH-1-step) from the bottom
  assign scan_pos = count_q + CW'(step_q) + CW'(1) - DepthC;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [lss_pkg::DataW-1:0] up_data;
      logic [lss_pkg::DataW-1:0] dn_data;
      logic                      hit_in;
      logic                      in_range;

      if (i == 0) begin : g_top
        assign up_data = req_i.value;
        assign hit_in  = 1'b0;
      end else begin : g_mid
        assign up_data = cell_data[i-1];
        assign hit_in  = cell_hit[i-1];
      end

      if (i == DEPTH - 1) begin : g_bot
        assign dn_data = '0;
      end else begin : g_nbot
        assign dn_data = cell_data[i+1];
      end

      // cell 0 is the top; cell i is occupied while i < count
      assign in_range = (CW'(i) < count_q);

      lss_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .key_i      (req_i.value),
        .up_data_i  (up_data),
        .dn_data_i  (dn_data),
        .hit_i      (hit_in),
        .in_range_i (in_range),
        .data_o     (cell_data[i]),
        .hit_o      (cell_hit[i])
      );
    end
  endgenerate

  // request decode and scan sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    ctrl         = '0;
    out_load     = 1'b0;
    out_status_d = lss_pkg::ST_OK;
    out_data_d   = '0;
    out_pos_d    = '0;
    out_count_d  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req_i.req_type)
            lss_pkg::REQ_PUSH: begin
              out_load = 1'b1;
              if (count_q >= DepthC) begin
                out_status_d = lss_pkg::ST_FULL;
              end else begin
                ctrl.push   = 1'b1;
                count_d     = count_q + CW'(1);
                out_count_d = count_q + CW'(1);
              end
            end
            lss_pkg::REQ_POP: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_status_d = lss_pkg::ST_EMPTY;
              end else begin
                ctrl.pop    = 1'b1;
                out_data_d  = cell_data[0];
                count_d     = count_q - CW'(1);
                out_count_d = count_q - CW'(1);
              end
            end
            lss_pkg::REQ_SEARCH: begin
              if (count_q == '0) begin
                out_load     = 1'b1;
                out_status_d = lss_pkg::ST_NOT_FOUND;
              end else begin
                ctrl.load = 1'b1;
                step_d    = '0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              // unused code: no change, plain ok result
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tail_hit || (step_q == LastStep)) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
            if (tail_hit) begin
              out_pos_d = scan_pos;
            end else begin
              out_status_d = lss_pkg::ST_NOT_FOUND;
            end
          end
        end else begin
          ctrl.shift = 1'b1;
          step_d     = step_q + JW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
    end
  end

  // position and count leave as their low four bits
  logic [CW+lss_pkg::OutW-1:0] pos_ext;
  logic [CW+lss_pkg::OutW-1:0] count_ext;
  assign pos_ext   = {{lss_pkg::OutW{1'b0}}, out_pos_q};
  assign count_ext = {{lss_pkg::OutW{1'b0}}, out_count_q};

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.data     = out_data_q;
  assign rsp_o.position = pos_ext[lss_pkg::OutW-1:0];
  assign rsp_o.count    = count_ext[lss_pkg::OutW-1:0];

endmodule
